[rtl/base64_encoder_macros.svh]
// Assertion macros used by the checking code of the encoder.
`ifndef BASE64_ENCODER_MACROS_SVH
`define BASE64_ENCODER_MACROS_SVH

// The consequent must hold on the same edge as the antecedent.
`define B64E_ASSERT_NOW(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("base64 encoder check failed");

// The consequent must hold on the edge after the antecedent.
`define B64E_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("base64 encoder check failed");

`endif

[rtl/b64e_pkg.sv]
package b64e_pkg;

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       end_of_text;
  } out_item_t;

  // One closed group: up to three bytes left-aligned, how many carry data,
  // and whether it ends the stream.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  count;
    logic        last;
  } group_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

  function automatic logic is_out_code(input logic [6:0] c);
    return (c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A) ||
           (c >= 7'h30 && c <= 7'h39) || (c == 7'h2B) || (c == 7'h2F) ||
           (c == PAD_CHAR);
  endfunction

endpackage

[rtl/b64e_front.sv]
module b64e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  b64e_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              in_full,
  output logic              q_push,
  output b64e_pkg::group_t  q_group
);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        accept;
  logic [23:0] word;
  logic [1:0]  count;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    unique case (pos_r)
      2'd1: begin
        word  = {held_r[15:8], in_item.data_byte, 8'h00};
        count = 2'd2;
      end
      2'd2: begin
        word  = {held_r, in_item.data_byte};
        count = 2'd3;
      end
      default: begin
        word  = {in_item.data_byte, 16'h0000};
        count = 2'd1;
      end
    endcase

    q_push        = accept && (count == 2'd3 || in_item.last_byte);
    q_group.word  = word;
    q_group.count = count;
    q_group.last  = in_item.last_byte;

    held_nxt = held_r;
    pos_nxt  = pos_r;
    if (accept) begin
      if (q_push) begin
        held_nxt = 16'h0000;
        pos_nxt  = 2'd0;
      end else begin
        held_nxt = word[23:8];
        pos_nxt  = count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 16'h0000;
      pos_r  <= 2'd0;
    end else begin
      held_r <= held_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

[rtl/b64e_queue.sv]
module b64e_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64e_pkg::group_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output b64e_pkg::group_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64e_pkg::group_t mem [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/b64e_back.sv]
module b64e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  b64e_pkg::group_t    q_head,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output b64e_pkg::out_item_t out_item
);

  logic [1:0]          idx_r, idx_nxt;
  logic                valid_r, valid_nxt;
  b64e_pkg::out_item_t item_r, item_nxt;
  logic                load;
  logic [5:0]          sextet;
  logic                pad;

  assign out_empty = !valid_r;
  assign out_item  = item_r;

  always_comb begin
    unique case (idx_r)
      2'd0: sextet = q_head.word[23:18];
      2'd1: sextet = q_head.word[17:12];
      2'd2: sextet = q_head.word[11:6];
      default: sextet = q_head.word[5:0];
    endcase
    pad = (idx_r == 2'd2 && q_head.count < 2'd2) ||
          (idx_r == 2'd3 && q_head.count < 2'd3);

    // The output register takes a new character whenever it is free or drained and the queue holds a group.
    load      = !valid_r || out_pop;
    q_pop     = load && !q_empty && idx_r == 2'd3;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        item_nxt.out_char    = pad ? b64e_pkg::PAD_CHAR : b64e_pkg::b64_char(sextet);
        item_nxt.end_of_text = q_head.last && idx_r == 2'd3;
        idx_nxt              = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

[rtl/base64_encoder.sv]
// A byte that closes a group is written into the queue, and its first character is then
// loaded into the output register. Throughput: one character per cycle while out_pop drains
// the output and the queue holds groups; the output register sets that figure.
// in_full, which stops new bytes, rises when QUEUE_DEPTH closed groups fill the queue.
// Reset (rst_n low, synchronous) drops held bytes, queued groups and the output.
module base64_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  b64e_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output b64e_pkg::out_item_t out_item
);

  logic             q_push, q_pop, q_full, q_empty;
  b64e_pkg::group_t q_in, q_head;

  b64e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .q_full  (q_full),
    .in_full (in_full),
    .q_push  (q_push),
    .q_group (q_in)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

[rtl/b64e_checker.sv]
`include "base64_encoder_macros.svh"

module b64e_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input b64e_pkg::out_item_t out_item
);

  // Reset leaves nothing to deliver and room for new requests.
  `B64E_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, out_empty && !in_full)

  // A waiting result that is not taken stays as it is.
  `B64E_ASSERT_NEXT(a_hold, clk, !rst_n, !out_empty && !out_pop, !out_empty && $stable(out_item))

  // Every delivered code is from the alphabet or is the pad.
  `B64E_ASSERT_NOW(a_code, clk, !rst_n, !out_empty, b64e_pkg::is_out_code(out_item.out_char))

  // A pad character is never followed by a data character in the same group.
  `B64E_ASSERT_NEXT(a_pad_tail, clk, !rst_n,
    !out_empty && out_pop && out_item.out_char == b64e_pkg::PAD_CHAR && !out_item.end_of_text,
    out_empty || out_item.out_char == b64e_pkg::PAD_CHAR)

endmodule

bind base64_encoder b64e_checker u_b64e_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);

[tb/sv/base64_encoder_tb.sv]
module base64_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_REQS = 262;

  // Standard alphabet, first character in the top byte.
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    b64e_pkg::in_item_t req;
    logic [7:0]         gap;
    logic               drain_first;
  } pending_req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  b64e_pkg::in_item_t  in_item = '0;
  logic                in_full;
  logic                out_empty;
  logic                out_pop = 1'b0;
  b64e_pkg::out_item_t out_item;

  pending_req_t        pending_reqs[$];
  b64e_pkg::out_item_t expected_chars[$];

  logic [15:0] held_bytes = '0;
  logic [1:0]  group_pos = '0;

  int gap_left = -1;
  int reqs_total = 0;
  int reqs_accepted = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int pop_hold = 0;
  int pop_free_run = 0;

  base64_encoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    c = ALPHABET[8*(63 - v) +: 8];
    return c[6:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_req(input logic [7:0] b, input logic lst, input int gap,
                         input logic drain);
    pending_req_t p;
    p.req.data_byte = b;
    p.req.last_byte = lst;
    p.gap = 8'(gap);
    p.drain_first = drain;
    pending_reqs = {pending_reqs, p};
  endtask

  task automatic push_char(input logic [6:0] ch, input logic eot);
    b64e_pkg::out_item_t o;
    o.out_char = ch;
    o.end_of_text = eot;
    expected_chars = {expected_chars, o};
  endtask

  // Gathers the byte into the open group; a full group, or one closed by the
  // last byte, yields four characters with padding for the missing bytes.
  task automatic predict_chars(input b64e_pkg::in_item_t req);
    logic [23:0] word;
    int n;
    case (group_pos)
      2'd1: begin
        word = {held_bytes[15:8], req.data_byte, 8'h00};
        n = 2;
      end
      2'd2: begin
        word = {held_bytes, req.data_byte};
        n = 3;
      end
      default: begin
        word = {req.data_byte, 16'h0000};
        n = 1;
      end
    endcase
    if (n == 3 || req.last_byte) begin
      push_char(sextet_char(word[23:18]), 1'b0);
      push_char(sextet_char(word[17:12]), 1'b0);
      push_char(n >= 2 ? sextet_char(word[11:6]) : b64e_pkg::PAD_CHAR, 1'b0);
      push_char(n >= 3 ? sextet_char(word[5:0]) : b64e_pkg::PAD_CHAR, req.last_byte);
      held_bytes = '0;
      group_pos = '0;
    end else begin
      held_bytes = word[23:8];
      group_pos = 2'(n);
    end
  endtask

  always @(posedge clk) begin : drive_reqs
    logic presenting;
    presenting = in_push;
    if (!rst_n) begin
      presenting = 1'b0;
      gap_left = -1;
    end else begin
      if (in_push && !in_full) begin
        predict_chars(in_item);
        reqs_accepted++;
        presenting = 1'b0;
      end
      if (!presenting && pending_reqs.size() != 0) begin
        if (gap_left < 0) gap_left = pending_reqs[0].gap;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending_reqs[0].drain_first || expected_chars.size() == 0) begin
          in_item <= pending_reqs[0].req;
          pending_reqs.pop_front();
          gap_left = -1;
          presenting = 1'b1;
        end
      end
    end
    in_push <= presenting;
  end

  always @(posedge clk) begin : check_chars
    b64e_pkg::out_item_t want;
    logic pop_next;
    int roll;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_chars.size() == 0) begin
        $error("character 0x%0h arrived with no request behind it", out_item.out_char);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_item.out_char !== want.out_char) begin
          $error("out_char: expected 0x%0h, got 0x%0h", want.out_char, out_item.out_char);
          fail_count++;
        end
        if (out_item.end_of_text !== want.end_of_text) begin
          $error("end_of_text: expected %0b, got %0b", want.end_of_text,
                 out_item.end_of_text);
          fail_count++;
        end
      end
    end
    // Stalls come in short bursts, occasional long ones, and stretches without.
    pop_next = 1'b1;
    if (!rst_n) begin
      pop_next = 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold--;
      pop_next = 1'b0;
    end else if (pop_free_run > 0) begin
      pop_free_run--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        pop_free_run = $urandom_range(40, 120);
      end else if (roll < 28) begin
        pop_hold = $urandom_range(1, 3);
      end else if (roll < 31) begin
        pop_hold = $urandom_range(8, 30);
      end
      if (pop_hold > 0) begin
        pop_hold--;
        pop_next = 1'b0;
      end
    end
    out_pop <= pop_next;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n_random;
    int len;
    int k;
    logic burst;
    logic closed;
    logic lst;

    // Directed: one-byte and two-byte tails, a full closing group, extremes.
    add_req(8'h4D, 1'b1, 0, 1'b0);
    add_req(8'h4D, 1'b0, 0, 1'b0);
    add_req(8'h61, 1'b1, 0, 1'b0);
    add_req(8'h4D, 1'b0, 0, 1'b0);
    add_req(8'h61, 1'b0, 0, 1'b0);
    add_req(8'h6E, 1'b1, 0, 1'b0);
    add_req(8'h00, 1'b0, 2, 1'b0);
    add_req(8'h00, 1'b0, 0, 1'b0);
    add_req(8'h00, 1'b0, 0, 1'b0);
    add_req(8'hFF, 1'b0, 0, 1'b1);
    add_req(8'hFF, 1'b0, 0, 1'b0);
    add_req(8'hFF, 1'b0, 0, 1'b0);
    add_req(8'hFB, 1'b0, 0, 1'b0);
    add_req(8'hFF, 1'b1, 0, 1'b0);
    add_req(8'hFF, 1'b1, 0, 1'b0);
    add_req(8'h00, 1'b1, 0, 1'b0);
    add_req(8'hAA, 1'b0, 0, 1'b0);
    add_req(8'h55, 1'b1, 0, 1'b0);

    n_random = 0;
    while (n_random < RANDOM_REQS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 9);
      if (len > RANDOM_REQS - n_random) len = RANDOM_REQS - n_random;
      burst = ($urandom_range(0, 3) == 0);
      closed = ($urandom_range(0, 4) != 0);
      for (k = 0; k < len; k++) begin
        lst = (k == len - 1) ? closed : ($urandom_range(0, 29) == 0);
        add_req(pick_byte(), lst, burst ? 0 : pick_gap(),
                n_random == 0 || $urandom_range(0, 59) == 0);
        n_random++;
      end
    end
    reqs_total = pending_reqs.size();

    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_accepted < reqs_total) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
